// ===== sv/hypergraph_pagerank_assert.svh =====
// Assertion macros used by the hypergraph PageRank module.
`ifndef HYPERGRAPH_PAGERANK_ASSERT_SVH
`define HYPERGRAPH_PAGERANK_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define HPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that an implication holds in the cycle after its antecedent, outside reset.
`define HPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/hpr_pkg.sv =====
// Package with the types and constants of the hypergraph PageRank block.
package hpr_pkg;
    localparam int MaxVertices = 1024;
    localparam int MaxMembers  = 8192;
    localparam int VtxW        = $clog2(MaxVertices);
    localparam int NW          = VtxW + 1;
    localparam int MemAw       = $clog2(MaxMembers);
    localparam int CntW        = MemAw + 1;
    localparam int DegW        = 14;
    localparam logic [DegW-1:0] DegLimit = 14'd16383;

    localparam logic [1:0] RegDamping   = 2'd0;
    localparam logic [1:0] RegIterCount = 2'd1;
    localparam logic [1:0] RegVtxCount  = 2'd2;

    localparam logic CmdAppend = 1'b0;
    localparam logic CmdQuery  = 1'b1;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [47:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEG_INC,
        S_BASE_DIV,
        S_INIT_DIV,
        S_INIT_FILL,
        S_ITER_START,
        S_BASE_FILL,
        S_MEM_RD,
        S_MEM_WAIT,
        S_MEM_EVAL,
        S_DEG_WAIT,
        S_SHARE_DIV,
        S_ADD_RD,
        S_ADD_WAIT,
        S_ADD_WR,
        S_COPY_RD,
        S_COPY_WAIT,
        S_COPY_WR,
        S_RES_RD,
        S_RES_WAIT,
        S_OUT
    } t_state;
endpackage

// ===== sv/hpr_divider.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
module hpr_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hpr_pkg::t_div_req i_req,
    output hpr_pkg::t_div_rsp o_rsp
);
    import hpr_pkg::*;

    t_div_state r_state, n_state;
    logic [63:0] r_quo;
    logic [48:0] r_rem;
    logic [47:0] r_den;
    logic [5:0]  r_cnt;
    logic [48:0] w_shift;
    logic [48:0] w_diff;

    assign w_shift = {r_rem[47:0], r_quo[63]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_cnt <= '0;
        end else if (r_state == DIV_RUN) begin
            r_cnt <= r_cnt + 6'd1;
            if (!w_diff[48]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (i_req.start) n_state = DIV_RUN;
            DIV_RUN:  if (r_cnt == 6'd63) n_state = DIV_DONE;
            DIV_DONE: n_state = i_req.start ? DIV_RUN : DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    assign o_rsp.done     = (r_state == DIV_DONE);
    assign o_rsp.quotient = r_quo;
endmodule

// ===== sv/hypergraph_pagerank.sv =====
// An append is accepted in S_IDLE; one that starts an edge that is stored then passes through S_DEG_INC.
// A query runs the base and initial-score divisions, fills the scores, then runs the iterations over the
// members and reads the result before offering it at the output.
// Throughput: one transaction at a time.
// Reset: synchronous active low; degrees are cleared by a pass over all 1024 entries after reset
// during which no transaction is accepted. The member and score memories are not cleared.
module hypergraph_pagerank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [9:0]  i_vertex,
    input  logic        i_last_of_edge,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_score,
    output logic        o_saturated,
    output logic        o_store_overflow
);
    import hpr_pkg::*;
    `include "hypergraph_pagerank_assert.svh"

    logic [15:0] r_damping;
    logic [7:0]  r_iters;
    logic [10:0] r_vcount;

    logic [VtxW:0]   r_member_mem [MaxMembers];
    logic [DegW-1:0] r_deg_mem    [MaxVertices];
    logic [31:0]     r_old_mem    [MaxVertices];
    logic [31:0]     r_new_mem    [MaxVertices];

    t_state r_state, n_state;
    logic [CntW-1:0] r_mcount;
    logic            r_estart;
    logic            r_ovf;
    logic            r_clr;
    logic [VtxW-1:0] r_clr_idx;

    logic [NW-1:0]   r_n;
    logic [31:0]     r_base;
    logic [31:0]     r_init;
    logic [NW-1:0]   r_i;
    logic [CntW-1:0] r_m;
    logic [7:0]      r_it;
    logic [VtxW:0]   r_ent;
    logic [DegW-1:0] r_deg_rd;
    logic [VtxW-1:0] r_av;
    logic [31:0]     r_old_rd;
    logic [31:0]     r_new_rd;
    logic [31:0]     r_share;
    logic            r_active;
    logic            r_sat;
    logic [VtxW-1:0] r_qv;
    logic            r_qv_ok;
    logic [31:0]     r_score;
    logic            r_out_valid;
    logic [31:0]     r_out_score;
    logic            r_out_sat;
    logic            r_out_ovf;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    hpr_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    logic [1:0]  w_reg_idx;
    logic        w_wr;
    logic        w_in_acc;
    logic        w_app;
    logic [NW-1:0] w_neff;
    logic [VtxW-1:0] w_w;
    logic        w_w_ok;
    logic [32:0] w_sum;
    logic [47:0] w_prod;
    logic        w_load;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;
    assign o_ready   = (r_state == S_IDLE) && !r_clr;
    assign w_in_acc  = i_valid && o_ready;
    assign w_app     = w_in_acc && (i_cmd == CmdAppend);
    assign w_w       = r_ent[VtxW-1:0];
    assign w_w_ok    = ({1'b0, w_w} < r_n);
    assign w_sum     = {1'b0, r_new_rd} + {1'b0, r_share};
    assign w_prod    = r_damping * r_old_rd;
    assign w_load    = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        if (r_vcount == '0) begin
            w_neff = NW'(1);
        end else if (r_vcount > NW'(MaxVertices)) begin
            w_neff = NW'(MaxVertices);
        end else begin
            w_neff = r_vcount;
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            RegDamping:   prdata = {16'd0, r_damping};
            RegIterCount: prdata = {24'd0, r_iters};
            RegVtxCount:  prdata = {21'd0, r_vcount};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping <= 16'd55706;
            r_iters   <= 8'd100;
            r_vcount  <= 11'd1;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                RegDamping:   r_damping <= pwdata[15:0];
                RegIterCount: r_iters   <= pwdata[7:0];
                RegVtxCount:  r_vcount  <= pwdata[10:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = '0;
        w_dreq.divisor  = {32'd0, 5'd0, r_n};
        n_state         = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_cmd == CmdQuery) begin
                    n_state         = S_BASE_DIV;
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = {39'd0, (17'h10000 - {1'b0, r_damping}), 8'd0};
                    w_dreq.divisor  = {32'd0, 5'd0, w_neff};
                end else if (w_app && r_estart && r_mcount < CntW'(MaxMembers)) begin
                    n_state = S_DEG_INC;
                end
            end
            S_DEG_INC:    n_state = S_IDLE;
            S_BASE_DIV: begin
                if (w_drsp.done) begin
                    n_state         = S_INIT_DIV;
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = 64'h0000_0000_0100_0000;
                end
            end
            S_INIT_DIV:   if (w_drsp.done) n_state = S_INIT_FILL;
            S_INIT_FILL:  if (r_i == r_n - NW'(1)) n_state = S_ITER_START;
            S_ITER_START: n_state = (r_it == r_iters) ? S_RES_RD : S_BASE_FILL;
            S_BASE_FILL:  if (r_i == r_n - NW'(1)) n_state = S_MEM_RD;
            S_MEM_RD:     n_state = (r_m == r_mcount) ? S_COPY_RD : S_MEM_WAIT;
            S_MEM_WAIT:   n_state = S_MEM_EVAL;
            S_MEM_EVAL: begin
                if (r_ent[VtxW]) begin
                    n_state = w_w_ok ? S_DEG_WAIT : S_MEM_RD;
                end else begin
                    n_state = (r_active && w_w_ok) ? S_ADD_RD : S_MEM_RD;
                end
            end
            S_DEG_WAIT: begin
                if (r_deg_rd == '0) begin
                    n_state = S_MEM_RD;
                end else begin
                    n_state         = S_SHARE_DIV;
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = {16'd0, w_prod};
                    w_dreq.divisor  = {18'd0, r_deg_rd, 16'd0};
                end
            end
            S_SHARE_DIV:  if (w_drsp.done) n_state = S_ADD_RD;
            S_ADD_RD:     n_state = S_ADD_WAIT;
            S_ADD_WAIT:   n_state = S_ADD_WR;
            S_ADD_WR:     n_state = S_MEM_RD;
            S_COPY_RD:    n_state = S_COPY_WAIT;
            S_COPY_WAIT:  n_state = S_COPY_WR;
            S_COPY_WR:    n_state = (r_i == r_n - NW'(1)) ? S_ITER_START : S_COPY_RD;
            S_RES_RD:     n_state = S_RES_WAIT;
            S_RES_WAIT:   n_state = S_OUT;
            S_OUT:        if (w_load) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mcount    <= '0;
            r_estart    <= 1'b1;
            r_ovf       <= 1'b0;
            r_clr       <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + VtxW'(1);
                if (r_clr_idx == VtxW'(MaxVertices - 1)) r_clr <= 1'b0;
            end
            if (w_app) begin
                r_estart <= i_last_of_edge;
                if (r_mcount < CntW'(MaxMembers)) begin
                    r_mcount <= r_mcount + CntW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_deg_mem[r_clr_idx] <= '0;
        end else if (r_state == S_DEG_INC && r_deg_rd != DegLimit) begin
            r_deg_mem[r_av] <= r_deg_rd + DegW'(1);
        end
        if (w_app && r_mcount < CntW'(MaxMembers)) begin
            r_member_mem[r_mcount[MemAw-1:0]] <= {r_estart, i_vertex};
        end
    end

    // An append that starts a stored edge reads the degree at acceptance and writes it back
    // incremented in the following cycle, unless it is already at DegLimit.
    always_ff @(posedge i_clk) begin
        if (w_app) begin
            r_deg_rd <= r_deg_mem[i_vertex];
            r_av     <= i_vertex;
        end else if (r_state == S_MEM_EVAL) begin
            r_deg_rd <= r_deg_mem[w_w];
        end
        if (r_state == S_MEM_RD) r_ent <= r_member_mem[r_m[MemAw-1:0]];
        if (r_state == S_MEM_EVAL || r_state == S_RES_RD) begin
            r_old_rd <= r_old_mem[(r_state == S_RES_RD) ? r_qv : w_w];
        end
        if (r_state == S_ADD_RD) r_new_rd <= r_new_mem[w_w];
        if (r_state == S_COPY_RD) r_new_rd <= r_new_mem[r_i[VtxW-1:0]];
        if (r_state == S_INIT_FILL) r_old_mem[r_i[VtxW-1:0]] <= r_init;
        if (r_state == S_COPY_WR) r_old_mem[r_i[VtxW-1:0]] <= r_new_rd;
        if (r_state == S_BASE_FILL) r_new_mem[r_i[VtxW-1:0]] <= r_base;
        if (r_state == S_ADD_WR) begin
            r_new_mem[w_w] <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_cmd == CmdQuery) begin
            r_n     <= w_neff;
            r_qv    <= i_vertex;
            r_qv_ok <= ({1'b0, i_vertex} < w_neff);
            r_sat   <= 1'b0;
            r_it    <= '0;
            r_i     <= '0;
        end
        if (r_state == S_BASE_DIV && w_drsp.done) r_base <= w_drsp.quotient[31:0];
        if (r_state == S_INIT_DIV && w_drsp.done) r_init <= w_drsp.quotient[31:0];
        if (r_state == S_INIT_FILL || r_state == S_BASE_FILL || r_state == S_COPY_WR) begin
            r_i <= (r_i == r_n - NW'(1)) ? '0 : r_i + NW'(1);
        end
        if (r_state == S_ITER_START) begin
            r_m      <= '0;
            r_active <= 1'b0;
            if (r_it != r_iters) r_it <= r_it + 8'd1;
        end
        if (r_state == S_MEM_RD && r_m != r_mcount) r_m <= r_m + CntW'(1);
        if (r_state == S_MEM_EVAL && r_ent[VtxW]) r_active <= 1'b0;
        if (r_state == S_DEG_WAIT && r_deg_rd != '0) r_active <= 1'b1;
        if (r_state == S_SHARE_DIV && w_drsp.done) r_share <= w_drsp.quotient[31:0];
        if (r_state == S_ADD_WR && w_sum[32]) r_sat <= 1'b1;
        if (r_state == S_RES_WAIT) r_score <= r_qv_ok ? r_old_rd : 32'd0;
        if (w_load) begin
            r_out_score <= r_score;
            r_out_sat   <= r_sat;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_score          = r_out_score;
    assign o_saturated      = r_out_sat;
    assign o_store_overflow = r_out_ovf;

    `HPR_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `HPR_ASSERT_IMPL(a_no_ready_clr, i_clk, i_rst_n, r_clr, !o_ready)
    `HPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_score))
    `HPR_ASSERT_IMPL(a_mcount_cap, i_clk, i_rst_n, 1'b1, r_mcount <= CntW'(MaxMembers))
endmodule

// ===== verif/tb_hypergraph_pagerank.sv =====
// Testbench for the hypergraph PageRank block: directed and random edge loads and queries checked by a scoreboard.
`timescale 1ns / 1ps

module tb_hypergraph_pagerank;
    import hpr_pkg::*;

    typedef struct {
        logic [31:0] score;
        logic        saturated;
        logic        overflow;
    } t_rank_result;

    class rank_scoreboard;
        logic [15:0]  damp;
        logic [7:0]   iters;
        logic [10:0]  vcount;
        logic [10:0]  members[MaxMembers];
        int           num_members;
        logic         at_edge_start;
        logic [13:0]  degree[MaxVertices];
        logic [31:0]  rank_old[MaxVertices];
        logic [31:0]  rank_new[MaxVertices];
        logic         dropped;
        t_rank_result pending_ranks[$];
        int           errors;

        function new();
            damp = 16'd55706;
            iters = 8'd100;
            vcount = 11'd1;
            num_members = 0;
            at_edge_start = 1'b1;
            dropped = 1'b0;
            errors = 0;
            foreach (degree[i]) degree[i] = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                RegDamping:   damp = val[15:0];
                RegIterCount: iters = val[7:0];
                RegVtxCount:  vcount = val[10:0];
                default: ;
            endcase
        endfunction

        function int active_vertices();
            if (vcount == 0) return 1;
            if (vcount > MaxVertices) return MaxVertices;
            return vcount;
        endfunction

        function logic rank_iterate(int n);
            logic              sat;
            logic              active;
            longint unsigned   share;
            longint unsigned   sum;
            logic [31:0]       base;
            int                w;
            sat = 1'b0;
            base = 32'((longint'(65536 - damp) << 8) / n);
            for (int i = 0; i < n; i++) rank_old[i] = 32'((64'd1 << 24) / n);
            for (int it = 0; it < iters; it++) begin
                share = 0;
                active = 1'b0;
                for (int i = 0; i < n; i++) rank_new[i] = base;
                for (int m = 0; m < num_members; m++) begin
                    w = members[m][9:0];
                    if (members[m][10]) begin
                        active = 1'b0;
                        if (w < n && degree[w] != 0) begin
                            share = (longint'(damp) * rank_old[w]) /
                                    (64'd65536 * degree[w]);
                            active = 1'b1;
                        end
                    end
                    if (active && w < n) begin
                        sum = longint'(rank_new[w]) + share;
                        if (sum > 64'hFFFF_FFFF) begin
                            sum = 64'hFFFF_FFFF;
                            sat = 1'b1;
                        end
                        rank_new[w] = sum[31:0];
                    end
                end
                for (int i = 0; i < n; i++) rank_old[i] = rank_new[i];
            end
            return sat;
        endfunction

        function void note_input(logic cmd, logic [9:0] v, logic last);
            t_rank_result r;
            int           n;
            if (cmd == CmdAppend) begin
                if (num_members < MaxMembers) begin
                    members[num_members] = {at_edge_start, v};
                    num_members++;
                    if (at_edge_start && degree[v] < DegLimit) degree[v]++;
                end else begin
                    dropped = 1'b1;
                end
                at_edge_start = last;
            end else begin
                n = active_vertices();
                r.saturated = rank_iterate(n);
                r.score = (v < n) ? rank_old[v] : 32'd0;
                r.overflow = dropped;
                pending_ranks.insert(pending_ranks.size(), r);
            end
        endfunction

        function void check_result(logic [31:0] score, logic sat, logic ovf);
            t_rank_result r;
            if (pending_ranks.size() == 0) begin
                $display("%0t: unexpected result score=%h", $time, score);
                errors++;
                return;
            end
            r = pending_ranks.pop_front();
            if (score !== r.score || sat !== r.saturated || ovf !== r.overflow) begin
                $display("%0t: mismatch expected score=%h sat=%b ovf=%b actual score=%h sat=%b ovf=%b",
                         $time, r.score, r.saturated, r.overflow, score, sat, ovf);
                errors++;
            end
        endfunction
    endclass

    localparam int WatchdogLimit = 800000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [9:0]  i_vertex = '0;
    logic        i_last_of_edge = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_score;
    logic        o_saturated;
    logic        o_store_overflow;

    rank_scoreboard sb = new();
    int  idle_pct = 38;
    bit  hold_request = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    hypergraph_pagerank dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_score, o_saturated, o_store_overflow);
            if ((o_valid && i_ready) || (i_valid && o_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
        if (hold_request) begin
            hold_request = 0;
            hold_left = 2000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_ranks.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] d, logic [7:0] it, logic [10:0] n);
        drain();
        reg_write(RegDamping, {16'd0, d});
        reg_write(RegIterCount, {24'd0, it});
        reg_write(RegVtxCount, {21'd0, n});
    endtask

    task automatic send_item(logic cmd, logic [9:0] v, logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_vertex <= v;
        i_last_of_edge <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(cmd, v, last);
    endtask

    function automatic logic [9:0] pick_vertex(int n);
        int top;
        top = (n + 1 > 1023) ? 1023 : n + 1;
        if ($urandom_range(0, 9) < 7) return 10'($urandom_range(0, top));
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic random_phase(int count, int query_pct, int max_len);
        int n;
        int len;
        int sent;
        n = sb.active_vertices();
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, max_len);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < query_pct) begin
                    send_item(CmdQuery, pick_vertex(n), 1'($urandom_range(0, 1)));
                    sent++;
                end
                send_item(CmdAppend, pick_vertex(n), (k == len - 1) ? 1'b1 :
                          ($urandom_range(0, 29) == 0));
                sent++;
            end
        end
    endtask

    logic [15:0] damps[8] = '{16'd0, 16'd65535, 16'd55706, 16'd1, 16'd40000,
                              16'd65535, 16'd30000, 16'd60000};
    logic [7:0]  iter_set[8] = '{8'd2, 8'd1, 8'd0, 8'd1, 8'd2, 8'd255, 8'd1, 8'd2};
    logic [10:0] nv_set[8] = '{11'd1, 11'd2, 11'd16, 11'd1024, 11'd0, 11'd3,
                               11'd2047, 11'd7};

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: defaults, saturation, out-of-range queries, clamped vertex counts.
        send_item(CmdQuery, 10'd0, 1'b0);
        configure(16'hFFFF, 8'd4, 11'd1);
        for (int k = 0; k < 8; k++) send_item(CmdAppend, 10'd0, k == 7);
        send_item(CmdQuery, 10'd0, 1'b1);
        send_item(CmdQuery, 10'd1023, 1'b0);
        configure(16'd0, 8'd0, 11'd0);
        send_item(CmdQuery, 10'd0, 1'b0);
        configure(16'd55706, 8'd1, 11'd2047);
        send_item(CmdAppend, 10'd1023, 1'b0);
        send_item(CmdAppend, 10'd512, 1'b1);
        send_item(CmdAppend, 10'd5, 1'b1);
        send_item(CmdQuery, 10'd1023, 1'b0);
        send_item(CmdQuery, 10'd5, 1'b0);
        configure(16'd65535, 8'd1, 11'd3);
        send_item(CmdAppend, 10'd700, 1'b0);
        send_item(CmdAppend, 10'd1, 1'b1);
        send_item(CmdQuery, 10'd2, 1'b0);
        // Touch the largest iteration count once on a small graph state.
        configure(16'd100, 8'd255, 11'd1);
        send_item(CmdQuery, 10'd0, 1'b0);

        for (int p = 0; p < 8; p++) begin
            configure((p == 6) ? 16'($urandom_range(0, 65535)) : damps[p],
                      (p == 5) ? 8'd0 : iter_set[p], nv_set[p]);
            if (p == 2) begin
                hold_request = 1;
                random_phase(150, 50, 6);
            end else if (p == 4) begin
                idle_pct = 0;
                random_phase(215, 3, 15);
                idle_pct = 38;
            end else begin
                random_phase(215, 3, 15);
            end
        end

        // A few more members and queries over the full vertex range.
        configure(16'($urandom_range(0, 65535)), 8'd1, 11'd1024);
        for (int k = 0; k < 20; k++)
            send_item(CmdAppend, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        send_item(CmdQuery, 10'($urandom_range(0, 1023)), 1'b0);
        send_item(CmdQuery, 10'd1023, 1'b1);

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_ranks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
